@@ rtl/core/wmdg_pkg.sv @@
// ----------------------------------------------------------------------------
// wmdg_pkg: shared constants for the window minimum distinct gap block
// Key width, default sizes and the key bias.
// ----------------------------------------------------------------------------
`default_nettype none
package wmdg_pkg;
  localparam int KEY_W            = 18;
  localparam int DEF_MAX_ITEMS    = 1024;
  localparam int DEF_DIGIT_BITS   = 9;
  localparam int DEF_BUCKETS      = 512;
  localparam logic [KEY_W-1:0] SIGN_FLIP = 18'h20000;
endpackage
`default_nettype wire

@@ rtl/core/wmdg_ram.sv @@
// ----------------------------------------------------------------------------
// wmdg_ram: generic single-port-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module wmdg_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/window_min_distinct_gap.sv @@
// ----------------------------------------------------------------------------
// window_min_distinct_gap: smallest positive gap between distinct set values
// Stores one set, radix sorts it in memory, and emits the minimum gap.
// ----------------------------------------------------------------------------
// Usage: feed the values of one window as beats on in_* (tdata = sample,
// tuser = last). Values load one per cycle into the value memory. The beat
// with last set starts the sort; in_tready stays low until the result beat
// on out_* (tdata = min_gap, tuser = overflow) has been taken.
// Sort: for each digit round, clear all BUCKETS counters, count the values
// (ST_CNT_R then ST_CNT_W, a counter read-modify-write per value), build a
// prefix sum over the buckets (ST_PS_R then ST_PS_W), and scatter from the
// end (ST_SC_R, ST_SC_B, ST_SC_W per value). Then the sorted keys are
// scanned for the minimum gap. With fewer than two values the result beat
// is offered on the next cycle after the last beat.
// Values past MAX_ITEMS are dropped and flag overflow. Reset empties the
// set; memory contents are not cleared. A stalled output holds its beat and
// the block takes no input until it is released.
// ----------------------------------------------------------------------------
`default_nettype none
module window_min_distinct_gap
  import wmdg_pkg::*;
#(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int DIGIT_BITS = DEF_DIGIT_BITS,
  parameter int BUCKETS    = DEF_BUCKETS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [17:0] sample
  input  wire logic        in_tuser,   // [0] last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [17:0] min_gap
  output logic             out_tuser   // [0] overflow
);
  localparam int AW     = $clog2(MAX_ITEMS);
  localparam int CW     = $clog2(MAX_ITEMS + 1);
  localparam int BW     = $clog2(BUCKETS);
  localparam int ROUNDS = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int RW     = $clog2(ROUNDS + 1);
  localparam int SW     = $clog2(KEY_W + DIGIT_BITS);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_CNT_R = 4'd2;
  localparam logic [3:0] ST_CNT_W = 4'd3;
  localparam logic [3:0] ST_PS_R  = 4'd4;
  localparam logic [3:0] ST_PS_W  = 4'd5;
  localparam logic [3:0] ST_SC_R  = 4'd6;
  localparam logic [3:0] ST_SC_B  = 4'd7;
  localparam logic [3:0] ST_SC_W  = 4'd8;
  localparam logic [3:0] ST_SCAN  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;    // value index
  logic [BW:0]      bidx_r, bidx_nxt;  // bucket index
  logic [CW-1:0]    acc_r, acc_nxt;
  logic [RW-1:0]    round_r, round_nxt;
  logic             sel_r, sel_nxt;    // 0: source is value memory
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] prev_r, prev_nxt;
  logic [KEY_W-1:0] best_r, best_nxt;
  logic             first_r, first_nxt;
  logic [SW-1:0]    shift_r, shift_nxt;

  // two key memories form the ping-pong pair
  logic             a_we, b_we, c_we;
  logic [AW-1:0]    a_wa, a_ra, b_wa, b_ra;
  logic [KEY_W-1:0] a_wd, a_rd, b_wd, b_rd;
  logic [BW-1:0]    c_wa, c_ra;
  logic [CW-1:0]    c_wd, c_rd;

  wmdg_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_val (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  wmdg_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_scr (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  wmdg_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_cnt (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

  logic [KEY_W-1:0] src_rd, shifted, in_key;
  logic [BW-1:0]    digit;
  logic [KEY_W-1:0] key_shifted;
  logic [BW-1:0]    key_digit;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             src_re_we, dst_we;
  logic [KEY_W-1:0] diff;

  assign in_key  = in_tdata[KEY_W-1:0] ^ SIGN_FLIP;
  assign src_rd  = sel_r ? b_rd : a_rd;
  assign shifted = src_rd >> shift_r;
  assign digit   = shifted[BW-1:0];
  assign key_shifted = key_r >> shift_r;
  assign key_digit   = key_shifted[BW-1:0];
  assign diff    = src_rd - prev_r;
  assign in_tready = (state_r == ST_LOAD);

  always_comb begin
    state_nxt = state_r;  cnt_nxt = cnt_r;    ovf_nxt = ovf_r;
    idx_nxt = idx_r;      bidx_nxt = bidx_r;  acc_nxt = acc_r;
    round_nxt = round_r;  sel_nxt = sel_r;    key_nxt = key_r;
    prev_nxt = prev_r;    best_nxt = best_r;  first_nxt = first_r;
    shift_nxt = shift_r;
    rd_addr = idx_r[AW-1:0];
    wr_addr = cnt_r[AW-1:0];
    wr_data = in_key;
    src_re_we = 1'b0;
    dst_we = 1'b0;
    c_we = 1'b0;
    c_wa = bidx_r[BW-1:0];
    c_ra = bidx_r[BW-1:0];
    c_wd = '0;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            src_re_we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tuser) begin
            round_nxt = '0; shift_nxt = '0; sel_nxt = 1'b0; bidx_nxt = '0;
            best_nxt = '0;
            if (cnt_nxt >= CW'(2)) state_nxt = ST_CLR;
            else                   state_nxt = ST_OUT;
          end
        end
      end
      ST_CLR: begin
        c_we = 1'b1;
        if (bidx_r == (BW+1)'(BUCKETS - 1)) begin
          idx_nxt = '0;
          rd_addr = '0;
          state_nxt = ST_CNT_R;
        end
        bidx_nxt = bidx_r + 1'b1;
      end
      ST_CNT_R: begin
        // source data valid now; fetch its counter
        c_ra = digit;
        key_nxt = src_rd;
        state_nxt = ST_CNT_W;
      end
      ST_CNT_W: begin
        c_we = 1'b1;
        c_wa = key_digit;
        c_wd = c_rd + 1'b1;
        idx_nxt = idx_r + 1'b1;
        rd_addr = idx_nxt[AW-1:0];
        if (idx_nxt == cnt_r) begin
          bidx_nxt = '0; acc_nxt = '0;
          state_nxt = ST_PS_R;
        end else begin
          state_nxt = ST_CNT_R;
        end
      end
      ST_PS_R: begin
        state_nxt = ST_PS_W;
      end
      ST_PS_W: begin
        c_we = 1'b1;
        c_wd = acc_r + c_rd;
        acc_nxt = acc_r + c_rd;
        bidx_nxt = bidx_r + 1'b1;
        c_ra = bidx_nxt[BW-1:0];
        if (bidx_r == (BW+1)'(BUCKETS - 1)) begin
          idx_nxt = cnt_r - 1'b1;
          rd_addr = idx_nxt[AW-1:0];
          state_nxt = ST_SC_R;
        end else begin
          state_nxt = ST_PS_R;
        end
      end
      ST_SC_R: begin
        c_ra = digit;
        key_nxt = src_rd;
        state_nxt = ST_SC_B;
      end
      ST_SC_B: begin
        // hold the counter address so its data stays on the read port
        c_ra = key_digit;
        state_nxt = ST_SC_W;
      end
      ST_SC_W: begin
        c_we = 1'b1;
        c_wa = key_digit;
        c_wd = c_rd - 1'b1;
        dst_we = 1'b1;
        wr_addr = c_wd[AW-1:0];
        wr_data = key_r;
        idx_nxt = idx_r - 1'b1;
        rd_addr = idx_nxt[AW-1:0];
        if (idx_r == '0) begin
          sel_nxt = ~sel_r;
          round_nxt = round_r + 1'b1;
          shift_nxt = shift_r + SW'(DIGIT_BITS);
          bidx_nxt = '0;
          idx_nxt = '0;
          rd_addr = '0;
          first_nxt = 1'b1;
          if (round_r == RW'(ROUNDS - 1)) state_nxt = ST_SCAN;
          else                            state_nxt = ST_CLR;
        end else begin
          state_nxt = ST_SC_R;
        end
      end
      ST_SCAN: begin
        // first cycle only primes the read
        if (first_r) begin
          first_nxt = 1'b0;
          idx_nxt = '0;
          rd_addr = '0;
        end else begin
          if (idx_r != '0 && diff != '0 && (best_r == '0 || diff < best_r))
            best_nxt = diff;
          prev_nxt = src_rd;
          idx_nxt = idx_r + 1'b1;
          rd_addr = idx_nxt[AW-1:0];
          if (idx_nxt == cnt_r) state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          cnt_nxt = '0; ovf_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // source memory is read at rd_addr; writes go to load or destination
  always_comb begin
    a_ra = rd_addr; b_ra = rd_addr;
    a_wa = wr_addr; b_wa = wr_addr;
    a_wd = wr_data; b_wd = wr_data;
    a_we = src_re_we || (dst_we && sel_r);
    b_we = dst_we && !sel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      bidx_r  <= '0;
      round_r <= '0;
      sel_r   <= 1'b0;
      first_r <= 1'b0;
      shift_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      bidx_r  <= bidx_nxt;
      round_r <= round_nxt;
      sel_r   <= sel_nxt;
      first_r <= first_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    key_r  <= key_nxt;
    prev_r <= prev_nxt;
    best_r <= best_nxt;
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {{(24-KEY_W){1'b0}}, best_r};
  assign out_tuser  = ovf_r;

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS)) else $error("item count past capacity");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(best_r))
    else $error("result changed while stalled");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> cnt_r == '0 && !ovf_r)
    else $error("set state not cleared");
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken during sort");
endmodule
`default_nettype wire
